@@ rtl/qpe_pkg.sv @@
package qpe_pkg;

  localparam int INDEX_WIDTH = 16;
  localparam int INDEX_OUT_W = 16;

  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 112;

  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 16;
  localparam int CNT_W      = 5;

  localparam logic [15:0] DIR_ONE   = 16'd16384;
  localparam logic [31:0] OFF_ROUND = 32'd8192;

  localparam logic [3:0] SLOT_V0   = 4'd0;
  localparam logic [3:0] SLOT_V1   = 4'd1;
  localparam logic [3:0] SLOT_V2   = 4'd2;
  localparam logic [3:0] SLOT_V3   = 4'd3;
  localparam logic [3:0] SLOT_IDX0 = 4'd4;
  localparam logic [3:0] SLOT_LAST = 4'd9;

  localparam logic MODE_LINE = 1'b0;
  localparam logic MODE_RECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_DSET,
    ST_DIV,
    ST_SCX,
    ST_SCY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
  } hs_ctrl_t;

  function automatic logic [1:0] idx_offset(input logic [3:0] slot);
    logic [1:0] o;
    unique case (slot)
      4'd4:    o = 2'd0;
      4'd5:    o = 2'd1;
      4'd6:    o = 2'd2;
      4'd7:    o = 2'd2;
      4'd8:    o = 2'd3;
      default: o = 2'd0;
    endcase
    return o;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] s;
    if (v > 18'sd32767) begin
      s = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      s = 16'sh8000;
    end else begin
      s = v[15:0];
    end
    return s;
  endfunction

endpackage

@@ rtl/quad_primitive_emitter_top.sv @@
// Channel   Dir  tdata fields / tuser / tlast
// in_*      in   start_x..tex1_v (176 bits) / mode / -
// out_*     out  pos_x..index_value (112 bits) / is_index / last
// A rectangle goes from acceptance straight to its ten words.
// For a line, one shared subtractor runs the 31-step square root
// and then two 16-step divides, and one shared 16x16 multiplier forms the
// squares and the offsets. Ten words follow at one a cycle when out_tready is high.
// Reset is synchronous and active low; it clears the sequencer and the vertex base.
// A stall on the output holds the word; no input is taken until the tenth word leaves.
module quad_primitive_emitter_top import qpe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // start_x, start_y, end_x, end_y, rgba, half_width, tex0_u, tex0_v, tex1_u,
  // tex1_v, then four zero bits
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pos_x, pos_y, tex_u, tex_v, vertex_rgba, index_value
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // is_index
  output logic                   out_tuser,
  output logic                   out_tlast
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [INDEX_WIDTH-1:0] base_r, base_nxt;
  logic axis_r, axis_nxt;
  hs_ctrl_t hs;

  logic               mode_r;
  logic signed [15:0] x0_r, y0_r, x1_r, y1_r;
  logic [31:0]        rgba_r;
  logic [11:0]        hw_r;
  logic [15:0]        u0_r, v0_r, u1_r, v1_r;

  logic [15:0] mag_x_r, mag_y_r;
  logic        neg_x_r, neg_y_r;
  logic [33:0] sq_n_r;
  logic [31:0] len_r;
  logic [31:0] rem_r;
  logic [30:0] root_r;
  logic [15:0] lo_r;
  logic [14:0] dmx_r, dmy_r;
  logic [11:0] ox_mag_r, oy_mag_r;
  logic        ox_neg_r, oy_neg_r;

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid && hs.in_ready;
  assign out_acc = hs.out_valid && out_tready;

  // Shared subtractor for the root and divide steps.
  logic [33:0] op_a, op_b;
  logic [34:0] diff;
  logic        ge;

  always_comb begin
    if (state_r == ST_SQRT) begin
      op_a = {rem_r, sq_n_r[33:32]};
      op_b = {1'b0, root_r, 2'b01};
    end else begin
      op_a = {2'b00, rem_r[30:0], lo_r[15]};
      op_b = {3'b000, root_r};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = !diff[34];
  end

  // Shared multiplier.
  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;
  logic [31:0] prod_rnd;

  always_comb begin
    unique case (state_r)
      ST_SQX:  begin mul_a = mag_x_r;        mul_b = mag_x_r;        end
      ST_SQY:  begin mul_a = mag_y_r;        mul_b = mag_y_r;        end
      ST_SCX:  begin mul_a = {1'b0, dmy_r};  mul_b = {4'd0, hw_r};   end
      default: begin mul_a = {1'b0, dmx_r};  mul_b = {4'd0, hw_r};   end
    endcase
    prod     = mul_a * mul_b;
    prod_rnd = prod + OFF_ROUND;
  end

  logic signed [16:0] dx, dy;
  assign dx = 17'(x1_r) - 17'(x0_r);
  assign dy = 17'(y1_r) - 17'(y0_r);

  logic [44:0] num;
  logic [15:0] qt;
  logic [14:0] dir_mag;

  always_comb begin
    num = {(axis_r ? mag_y_r : mag_x_r), 29'd0} >> 1;
    num = num + 45'(root_r[30:1]);
    qt  = {lo_r[14:0], ge};
    if (root_r == '0) begin
      dir_mag = '0;
    end else if (qt > DIR_ONE) begin
      dir_mag = 15'(DIR_ONE);
    end else begin
      dir_mag = qt[14:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == MODE_RECT) ? ST_EMIT : ST_DIFF;
        end
      end
      ST_DIFF: state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_DSET;
        end
      end
      ST_DSET: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = axis_r ? ST_SCX : ST_DSET;
        end
      end
      ST_SCX:  state_nxt = ST_SCY;
      ST_SCY:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_acc && cnt_r[3:0] == SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    hs.in_ready  = (state_r == ST_IDLE);
    hs.out_valid = (state_r == ST_EMIT);
  end

  always_comb begin
    if (state_nxt != state_r) begin
      cnt_nxt = '0;
    end else if (state_r == ST_EMIT) begin
      cnt_nxt = out_acc ? cnt_r + 1'b1 : cnt_r;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
    axis_nxt = axis_r;
    if (state_r == ST_SQRT) begin
      axis_nxt = 1'b0;
    end else if (state_r == ST_DIV && state_nxt != state_r) begin
      axis_nxt = 1'b1;
    end
    base_nxt = base_r;
    if (out_acc && cnt_r[3:0] == SLOT_LAST) begin
      base_nxt = base_r + INDEX_WIDTH'(4);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      base_r  <= '0;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_r <= in_tuser;
          x0_r   <= in_tdata[15:0];
          y0_r   <= in_tdata[31:16];
          x1_r   <= in_tdata[47:32];
          y1_r   <= in_tdata[63:48];
          rgba_r <= in_tdata[95:64];
          hw_r   <= in_tdata[107:96];
          u0_r   <= in_tdata[123:108];
          v0_r   <= in_tdata[139:124];
          u1_r   <= in_tdata[155:140];
          v1_r   <= in_tdata[171:156];
        end
      end
      ST_DIFF: begin
        neg_x_r <= dx[16];
        neg_y_r <= dy[16];
        mag_x_r <= dx[16] ? 16'(-dx) : dx[15:0];
        mag_y_r <= dy[16] ? 16'(-dy) : dy[15:0];
      end
      ST_SQX: begin
        len_r <= prod;
      end
      ST_SQY: begin
        sq_n_r <= 34'(len_r) + 34'(prod);
        rem_r  <= '0;
        root_r <= '0;
      end
      ST_SQRT: begin
        sq_n_r <= {sq_n_r[31:0], 2'b00};
        rem_r  <= ge ? diff[31:0] : op_a[31:0];
        root_r <= {root_r[29:0], ge};
      end
      ST_DSET: begin
        rem_r <= 32'(num[44:16]);
        lo_r  <= num[15:0];
      end
      ST_DIV: begin
        rem_r <= ge ? diff[31:0] : op_a[31:0];
        lo_r  <= qt;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          if (axis_r) begin
            dmy_r <= dir_mag;
          end else begin
            dmx_r <= dir_mag;
          end
        end
      end
      ST_SCX: begin
        ox_mag_r <= prod_rnd[25:14];
        ox_neg_r <= neg_y_r;
      end
      ST_SCY: begin
        oy_mag_r <= prod_rnd[25:14];
        oy_neg_r <= !neg_x_r;
      end
      default: begin
      end
    endcase
  end

  // Word assembly from the held primitive and the slot counter.
  logic [3:0]         slot;
  logic               is_idx;
  logic               corner_a, top_row, off_sub;
  logic signed [15:0] x_sel, y_sel;
  logic signed [12:0] offx, offy;
  logic signed [17:0] sum_x, sum_y;
  logic [15:0]        tu, tv;
  logic [INDEX_WIDTH-1:0] idx_full;
  logic [INDEX_OUT_W-1:0] idx_val;

  always_comb begin
    slot     = cnt_r[3:0];
    is_idx   = (slot >= SLOT_IDX0);
    corner_a = (slot == SLOT_V0) || (slot == SLOT_V3);
    top_row  = (slot == SLOT_V0) || (slot == SLOT_V1);
    off_sub  = top_row;
    x_sel    = corner_a ? x0_r : x1_r;
    if (mode_r == MODE_RECT) begin
      y_sel = top_row ? y0_r : y1_r;
      offx  = '0;
      offy  = '0;
      tu    = corner_a ? u0_r : u1_r;
      tv    = top_row ? v0_r : v1_r;
    end else begin
      y_sel = corner_a ? y0_r : y1_r;
      offx  = (ox_neg_r ^ off_sub) ? -$signed({1'b0, ox_mag_r}) : $signed({1'b0, ox_mag_r});
      offy  = (oy_neg_r ^ off_sub) ? -$signed({1'b0, oy_mag_r}) : $signed({1'b0, oy_mag_r});
      tu    = '0;
      tv    = '0;
    end
    sum_x    = 18'(x_sel) + 18'(offx);
    sum_y    = 18'(y_sel) + 18'(offy);
    idx_full = base_r + INDEX_WIDTH'(idx_offset(slot));
    idx_val  = INDEX_OUT_W'(idx_full);
  end

  assign in_tready  = hs.in_ready;
  assign out_tvalid = hs.out_valid;
  assign out_tuser  = is_idx;
  assign out_tlast  = (slot == SLOT_LAST);
  assign out_tdata  = is_idx ? {idx_val, 96'd0}
                             : {16'd0, rgba_r, tv, tu, sat16(sum_y), sat16(sum_x)};

endmodule

@@ rtl/qpe_checker.sv @@
module qpe_checker import qpe_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // The final word of a primitive is always an index word.
  a_last_is_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last word is not an index word");

  // The block never offers a word while it is taking a primitive.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while output valid");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready straight after an accepted primitive");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("not ready after the last word");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled word changed");

endmodule

bind quad_primitive_emitter_top qpe_checker u_qpe_checker (.*);

@@ sim/tb_quad_primitive_emitter_top.sv @@
module tb_quad_primitive_emitter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qpe_pkg::*;

  typedef struct {
    logic               mode;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic [31:0]        rgba;
    logic [11:0]        hw;
    logic [15:0]        u0;
    logic [15:0]        v0;
    logic [15:0]        u1;
    logic [15:0]        v1;
  } prim_t;

  typedef struct {
    logic        is_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [31:0] rgba;
    logic [15:0] index_value;
    logic        last;
  } word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  word_t       expected_words[$];
  logic [15:0] pred_vertex_base = '0;
  logic        steady = 1'b0;
  int          prims_sent = 0;
  int          mismatch_count = 0;

  quad_primitive_emitter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic int unit_comp(input int d, input longint unsigned root);
    longint unsigned mag;
    longint unsigned q;
    if (root == 0) return 0;
    mag = (d < 0) ? -d : d;
    q = ((mag << 28) + (root >> 1)) / root;
    if (q > 16384) q = 16384;
    return (d < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic int offset_comp(input int n, input int unsigned hw);
    int unsigned mag;
    int unsigned p;
    mag = (n < 0) ? -n : n;
    p = (mag * hw + 8192) >> 14;
    return (n < 0) ? -int'(p) : int'(p);
  endfunction

  function automatic logic [15:0] clamp16(input int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Works out the ten words of one primitive and advances the vertex base.
  function automatic void predict_quad(input prim_t p);
    int              dx, dy, ux, uy, ox, oy, k;
    longint unsigned len2, root;
    int              xs[4], ys[4];
    logic [15:0]     us[4], vs[4];
    int              offs[6];
    word_t           w;
    offs = '{0, 1, 2, 2, 3, 0};
    if (p.mode == MODE_LINE) begin
      dx = int'(p.x1) - int'(p.x0);
      dy = int'(p.y1) - int'(p.y0);
      len2 = longint'(dx) * dx + longint'(dy) * dy;
      root = int_sqrt(len2 << 28);
      ux = unit_comp(dx, root);
      uy = unit_comp(dy, root);
      ox = offset_comp(uy, 32'(p.hw));
      oy = offset_comp(-ux, 32'(p.hw));
      xs = '{p.x0 - ox, p.x1 - ox, p.x1 + ox, p.x0 + ox};
      ys = '{p.y0 - oy, p.y1 - oy, p.y1 + oy, p.y0 + oy};
      us = '{default: '0};
      vs = '{default: '0};
    end else begin
      xs = '{p.x0, p.x1, p.x1, p.x0};
      ys = '{p.y0, p.y0, p.y1, p.y1};
      us = '{p.u0, p.u1, p.u1, p.u0};
      vs = '{p.v0, p.v0, p.v1, p.v1};
    end
    for (k = 0; k < 4; k++) begin
      w = '{is_index: 1'b0, pos_x: clamp16(xs[k]), pos_y: clamp16(ys[k]), tex_u: us[k],
            tex_v: vs[k], rgba: p.rgba, index_value: '0, last: 1'b0};
      expected_words.insert(expected_words.size(), w);
    end
    for (k = 0; k < 6; k++) begin
      w = '{is_index: 1'b1, pos_x: '0, pos_y: '0, tex_u: '0, tex_v: '0, rgba: '0,
            index_value: pred_vertex_base + 16'(offs[k]), last: (k == 5)};
      expected_words.insert(expected_words.size(), w);
    end
    pred_vertex_base = pred_vertex_base + 16'd4;
  endfunction

  function automatic prim_t mk_line(input int x0, y0, x1, y1, input int hw,
                                    input logic [31:0] c);
    prim_t p;
    p = '{mode: MODE_LINE, x0: 16'(x0), y0: 16'(y0), x1: 16'(x1), y1: 16'(y1), rgba: c,
          hw: 12'(hw), u0: 16'($urandom), v0: 16'($urandom), u1: 16'($urandom),
          v1: 16'($urandom)};
    return p;
  endfunction

  function automatic prim_t mk_rect(input int x0, y0, x1, y1, input logic [31:0] c,
                                    input int u0, v0, u1, v1);
    prim_t p;
    p = '{mode: MODE_RECT, x0: 16'(x0), y0: 16'(y0), x1: 16'(x1), y1: 16'(y1), rgba: c,
          hw: 12'($urandom), u0: 16'(u0), v0: 16'(v0), u1: 16'(u1), v1: 16'(v1)};
    return p;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic prim_t random_prim(input logic mode);
    prim_t p;
    p.mode = mode;
    p.x0 = rand_coord();
    p.y0 = rand_coord();
    case ($urandom_range(9))
      0: begin
        p.x1 = p.x0;
        p.y1 = p.y0;
      end
      1, 2, 3: begin
        p.x1 = p.x0 + 16'($urandom_range(63)) - 16'd32;
        p.y1 = p.y0 + 16'($urandom_range(63)) - 16'd32;
      end
      default: begin
        p.x1 = rand_coord();
        p.y1 = rand_coord();
      end
    endcase
    p.rgba = $urandom;
    case ($urandom_range(7))
      0:       p.hw = '0;
      1:       p.hw = 12'hFFF;
      default: p.hw = 12'($urandom);
    endcase
    p.u0 = 16'($urandom);
    p.v0 = 16'($urandom);
    p.u1 = 16'($urandom);
    p.v1 = 16'($urandom);
    return p;
  endfunction

  task automatic send_prim(input prim_t p);
    while (!steady && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= p.mode;
    in_tdata  <= {4'b0, p.v1, p.u1, p.v0, p.u0, p.hw, p.rgba, p.y1, p.x1, p.y0, p.x0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_quad(p);
    prims_sent++;
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: tdata %h tuser %b tlast %b", out_tdata, out_tuser,
               out_tlast);
        mismatch_count++;
      end else begin
        w = expected_words.pop_front();
        check_field("is_index", 32'(w.is_index), 32'(out_tuser));
        check_field("pos_x", 32'(w.pos_x), 32'(out_tdata[15:0]));
        check_field("pos_y", 32'(w.pos_y), 32'(out_tdata[31:16]));
        check_field("tex_u", 32'(w.tex_u), 32'(out_tdata[47:32]));
        check_field("tex_v", 32'(w.tex_v), 32'(out_tdata[63:48]));
        check_field("vertex_rgba", w.rgba, out_tdata[95:64]);
        check_field("index_value", 32'(w.index_value), 32'(out_tdata[111:96]));
        check_field("last", 32'(w.last), 32'(out_tlast));
      end
    end
  end

  task automatic test_rect_corners();
    send_prim(mk_rect(-32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 0, 0, 'hFFFF, 'hFFFF));
    send_prim(mk_rect(32767, 32767, -32768, -32768, 32'h0000_0000, 'hFFFF, 'hFFFF, 0, 0));
    send_prim(mk_rect(100, -50, 100, -50, 32'h1234_5678, 'h8000, 'h0001, 'h0001, 'h8000));
    send_prim(mk_rect(-16, 48, 320, 400, 32'hA5A5_5A5A, 'h1234, 'h5678, 'h9ABC, 'hDEF0));
  endtask

  task automatic test_line_directions();
    send_prim(mk_line(0, 0, 160, 0, 16, 32'hFF00_00FF));
    send_prim(mk_line(0, 0, 0, 160, 16, 32'h00FF_00FF));
    send_prim(mk_line(0, 0, 160, 160, 32, 32'h0000_FFFF));
    send_prim(mk_line(160, 160, -160, -320, 40, 32'hFFFF_FFFF));
    send_prim(mk_line(0, 0, 1, 0, 4095, 32'h0));
    send_prim(mk_line(5, 5, 6, 6, 4095, 32'h1));
    send_prim(mk_line(0, 0, 3, -4, 1, 32'h2));
    send_prim(mk_line(-10, 20, 300, -700, 0, 32'h3));
    send_prim(mk_line(32767, 32767, 32767, -32768, 4095, 32'hDEAD_BEEF));
    send_prim(mk_line(-32768, -32768, 32767, 32767, 4095, 32'hCAFE_F00D));
    send_prim(mk_line(-32768, 32767, 32767, -32768, 4095, 32'h8000_0001));
    send_prim(mk_line(-32768, 0, -32768, 1, 4095, 32'h7FFF_FFFE));
  endtask

  task automatic test_zero_length_line();
    send_prim(mk_line(0, 0, 0, 0, 4095, 32'h0F0F_0F0F));
    send_prim(mk_line(32767, -32768, 32767, -32768, 4095, 32'hF0F0_F0F0));
    send_prim(mk_line(-123, 456, -123, 456, 0, 32'h5555_AAAA));
  endtask

  // Runs with no idling on either side, mostly with rectangles.
  task automatic test_no_idle();
    steady <= 1'b1;
    while (prims_sent < 120) begin
      send_prim(random_prim(($urandom_range(15) == 0) ? MODE_LINE : MODE_RECT));
    end
    steady <= 1'b0;
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_prim(random_prim(1'($urandom_range(1))));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rect_corners();
    test_line_directions();
    test_zero_length_line();
    test_no_idle();
    test_random_mix(360);
    in_tvalid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ quad_primitive_emitter_top.f @@
rtl/qpe_pkg.sv
rtl/quad_primitive_emitter_top.sv
rtl/qpe_checker.sv
sim/tb_quad_primitive_emitter_top.sv
